### hw/rtl/pdt_pkg.sv
// ----------------------------------------------------------------------------
// pdt_pkg: shared types and constants of the plane duplicate table
// Request and result structs, plane and token types, op and register codes.
// ----------------------------------------------------------------------------
package pdt_pkg;

  localparam int MAX_PLANES_DEF = 32;

  localparam int ENTRY_INDEX_W = 5;
  localparam int ENTRY_COUNT_W = 6;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 16;
  localparam int DIST_THR_W    = 15;
  localparam int COS_THR_W     = 16;

  localparam logic [DIST_THR_W-1:0] DIST_THR_RST = 15'd205;
  localparam logic [COS_THR_W-1:0]  COS_THR_RST  = 16'd30792;

  // Op codes; the unused code behaves as test only
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_TEST   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIST_THR = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS_THR  = 4'd1;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] offset_d;
  } in_req_t;

  typedef struct packed {
    logic                     not_seen;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic                     inserted;
    logic                     table_full;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } out_rsp_t;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [15:0] d;
  } plane_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic   vld;
    logic   found;
    plane_t plane;
  } pdt_tok_t;

  typedef struct packed {
    logic [DIST_THR_W-1:0] dist_thr;
    logic [COS_THR_W-1:0]  cos_thr;
  } pdt_thr_t;

endpackage

### hw/rtl/plane_duplicate_table_top.sv
// ----------------------------------------------------------------------------
// plane_duplicate_table_top: table of detected planes with duplicate search
// Tests incoming planes against stored ones, appends new ones, clears on
// request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A clear request
// gives its result in the cycle after acceptance. A test or insert request
// walks a token down a chain of MAX_PLANES cells, one cell per stored plane,
// each cell spending two register stages on it (products, then dot product
// sum and threshold compare); the result strobe out_valid rises once the
// token leaves the last cell and the result is registered. busy drops in the
// cycle the result is shown, so the next request may be taken there.
// out_valid is high for exactly one cycle with the result on out_rsp; the
// receiver cannot stall it, so it must take every result. The first stored
// plane that matches wins. Threshold writes are always taken (cfg_ready is
// tied high) and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module plane_duplicate_table_top
  import pdt_pkg::*;
#(
  parameter int MAX_PLANES = MAX_PLANES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  start,
  output logic                  busy,
  input  in_req_t               in_req,
  // result channel
  output logic                  out_valid,
  output out_rsp_t              out_rsp,
  // threshold registers
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int CNT_W = $clog2(MAX_PLANES + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_rsp_t         out_rsp_r, out_rsp_nxt;
  logic             head_vld_r, head_vld_nxt;
  plane_t           head_plane_r, head_plane_nxt;
  logic [1:0]       op_r, op_nxt;
  logic             wr_en;

  pdt_thr_t         thr_r;

  pdt_tok_t         tok_chain [0:MAX_PLANES];
  logic [IDX_W-1:0] idx_chain [0:MAX_PLANES];
  logic [MAX_PLANES-1:0] cell_vld;
  logic [MAX_PLANES-1:0] wr_sel;

  logic [IDX_W+ENTRY_INDEX_W-1:0] hit_idx_ext;
  logic [CNT_W+ENTRY_INDEX_W-1:0] ins_idx_ext;
  logic [CNT_W+ENTRY_COUNT_W-1:0] cnt_ext;

  // Threshold registers: take every write, drop unknown indexes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.dist_thr <= DIST_THR_RST;
      thr_r.cos_thr  <= COS_THR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DIST_THR: thr_r.dist_thr <= cfg_data[DIST_THR_W-1:0];
        REG_COS_THR:  thr_r.cos_thr  <= cfg_data[COS_THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Head of the chain: inject the search token
  assign tok_chain[0] = '{vld: head_vld_r, found: 1'b0, plane: head_plane_r};
  assign idx_chain[0] = '0;

  for (genvar i = 0; i < MAX_PLANES; i++) begin : g_cell
    // an entry takes part only when it lies below the fill count
    assign cell_vld[i] = count_r > CNT_W'(i);
    assign wr_sel[i]   = wr_en && (count_r == CNT_W'(i));

    pdt_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .thr      (thr_r),
      .cell_vld (cell_vld[i]),
      .wr_en    (wr_sel[i]),
      .wr_plane (head_plane_r),
      .tok_i    (tok_chain[i]),
      .idx_i    (idx_chain[i]),
      .tok_o    (tok_chain[i+1]),
      .idx_o    (idx_chain[i+1])
    );
  end

  assign hit_idx_ext = {{ENTRY_INDEX_W{1'b0}}, idx_chain[MAX_PLANES]};
  assign ins_idx_ext = {{ENTRY_INDEX_W{1'b0}}, count_r};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    head_vld_nxt   = 1'b0;
    head_plane_nxt = head_plane_r;
    op_nxt         = op_r;
    wr_en          = 1'b0;
    cnt_ext        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_req.op == OP_CLEAR) begin
            // clear answers at once with an all-zero result
            count_nxt     = '0;
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '0;
          end else begin
            head_vld_nxt   = 1'b1;
            head_plane_nxt = '{nx: in_req.normal_x, ny: in_req.normal_y,
                               nz: in_req.normal_z, d: in_req.offset_d};
            op_nxt         = in_req.op;
            state_nxt      = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        // hold until the token leaves the last cell
        if (tok_chain[MAX_PLANES].vld) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '0;
          if (tok_chain[MAX_PLANES].found) begin
            out_rsp_nxt.entry_index = hit_idx_ext[ENTRY_INDEX_W-1:0];
          end else begin
            out_rsp_nxt.not_seen = 1'b1;
            if (op_r == OP_INSERT) begin
              if (count_r < CNT_W'(MAX_PLANES)) begin
                // append at the fill count; the head register still holds the plane
                wr_en                   = 1'b1;
                count_nxt               = count_r + 1'b1;
                out_rsp_nxt.inserted    = 1'b1;
                out_rsp_nxt.entry_index = ins_idx_ext[ENTRY_INDEX_W-1:0];
              end else begin
                out_rsp_nxt.table_full = 1'b1;
              end
            end
          end
          cnt_ext                 = {{ENTRY_COUNT_W{1'b0}}, count_nxt};
          out_rsp_nxt.entry_count = cnt_ext[ENTRY_COUNT_W-1:0];
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      head_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      head_vld_r  <= head_vld_nxt;
    end
    out_rsp_r    <= out_rsp_nxt;
    head_plane_r <= head_plane_nxt;
    op_r         <= op_nxt;
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PLANES))
    else $error("fill count beyond table size");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_SEARCH || (start && !busy)))
    else $error("result without a request");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.inserted) |-> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not advance fill count");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.table_full) |-> (count_r == CNT_W'(MAX_PLANES)))
    else $error("table full flagged with room left");

  a_tail_while_search: assert property (@(posedge clk) disable iff (!rst_n)
    tok_chain[MAX_PLANES].vld |-> (state_r == ST_SEARCH))
    else $error("token left chain outside a search");

endmodule

### hw/rtl/pdt_cell.sv
// ----------------------------------------------------------------------------
// pdt_cell: one table entry with its own plane comparator
// Holds one stored plane, compares the passing token against it over two
// register stages and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module pdt_cell
  import pdt_pkg::*;
#(
  parameter int IDX_W    = 5,
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pdt_thr_t         thr,
  input  logic             cell_vld,
  input  logic             wr_en,
  input  plane_t           wr_plane,
  input  pdt_tok_t         tok_i,
  input  logic [IDX_W-1:0] idx_i,
  output pdt_tok_t         tok_o,
  output logic [IDX_W-1:0] idx_o
);

  plane_t            entry_r;

  pdt_tok_t          s1_tok_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic signed [31:0] s1_px_r, s1_py_r, s1_pz_r;
  logic              s1_dist_ok_r;
  logic              s1_vld_ok_r;

  pdt_tok_t          s2_tok_r;
  logic [IDX_W-1:0]  s2_idx_r;

  logic signed [31:0] px_nxt, py_nxt, pz_nxt;
  logic signed [16:0] d_diff;
  logic [16:0]        d_abs;
  logic               dist_ok_nxt;
  logic signed [32:0] dot_sum;
  logic [32:0]        dot_abs;
  logic               hit;
  pdt_tok_t           s2_tok_nxt;
  logic [IDX_W-1:0]   s2_idx_nxt;

  // Stage 1: products and offset check
  always_comb begin
    px_nxt      = 32'(entry_r.nx) * 32'(tok_i.plane.nx);
    py_nxt      = 32'(entry_r.ny) * 32'(tok_i.plane.ny);
    pz_nxt      = 32'(entry_r.nz) * 32'(tok_i.plane.nz);
    d_diff      = 17'(entry_r.d) - 17'(tok_i.plane.d);
    d_abs       = d_diff[16] ? 17'(-d_diff) : 17'(d_diff);
    dist_ok_nxt = d_abs <= {2'b00, thr.dist_thr};
  end

  // Stage 2: dot product magnitude and first-match merge
  always_comb begin
    dot_sum    = 33'(s1_px_r) + 33'(s1_py_r) + 33'(s1_pz_r);
    dot_abs    = dot_sum[32] ? 33'(-dot_sum) : 33'(dot_sum);
    hit        = s1_vld_ok_r && s1_dist_ok_r &&
                 (dot_abs >= {2'b00, thr.cos_thr, 15'd0});
    s2_tok_nxt = s1_tok_r;
    s2_idx_nxt = s1_idx_r;
    if (!s1_tok_r.found && hit) begin
      s2_tok_nxt.found = 1'b1;
      s2_idx_nxt       = IDX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_plane;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tok_r.vld <= 1'b0;
      s2_tok_r.vld <= 1'b0;
    end else begin
      s1_tok_r <= tok_i;
      s2_tok_r <= s2_tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r     <= idx_i;
    s1_px_r      <= px_nxt;
    s1_py_r      <= py_nxt;
    s1_pz_r      <= pz_nxt;
    s1_dist_ok_r <= dist_ok_nxt;
    s1_vld_ok_r  <= cell_vld;
    s2_idx_r     <= s2_idx_nxt;
  end

  assign tok_o = s2_tok_r;
  assign idx_o = s2_idx_r;

endmodule
